// File: rtl/shash_pkg.sv
// ----------------------------------------------------------------------------
// shash_pkg
// Shared types, op codes, round constants and SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package shash_pkg;

	// op codes of the command item
	localparam logic [1:0] OP_ABSORB = 2'd0;
	localparam logic [1:0] OP_FINAL  = 2'd1;
	localparam logic [1:0] OP_INIT   = 2'd2;

	// padding and length constants
	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [63:0] BLOCK_BITS = 64'd512;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] byte_value;
	} cmd_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        last;
	} digest_t;

	// working variables a..h, index 0 is a
	typedef logic [7:0][31:0] work_t;

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			3'd7: r = 32'h5be0cd19;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] r;
		case (t)
			6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/shash_round.sv
// ----------------------------------------------------------------------------
// shash_round
// One SHA-256 compression round on the working variables a..h.
// ----------------------------------------------------------------------------
module shash_round (
	input  shash_pkg::work_t v,
	input  logic [31:0]      w,
	input  logic [31:0]      k,
	output shash_pkg::work_t v_next
);
	import shash_pkg::*;

	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;

	// choice and majority
	assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
	assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);

	// temporaries
	assign t1 = v[7] + big_sigma1(v[4]) + ch + k + w;
	assign t2 = big_sigma0(v[0]) + maj;

	// rotate the variables
	always_comb begin
		v_next[0] = t1 + t2;
		v_next[1] = v[0];
		v_next[2] = v[1];
		v_next[3] = v[2];
		v_next[4] = v[3] + t1;
		v_next[5] = v[4];
		v_next[6] = v[5];
		v_next[7] = v[6];
	end

endmodule

// File: rtl/sha256_stream_hasher.sv
// Absorb: the 64th byte of a block starts a compression (hash load, 64 rounds at one per cycle,
// then add-back through the hash memory).
// Finalize runs one or two compressions, then emits the eight digest words, each held while stalled.
// Commands stall during compression and digest output, so no new byte is taken until a block is done.
// Reset: counters clear and the hash memory reads as the initial hash values through
// per-word valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream with init, absorb and finalize commands; the hash
// words and the block words live in small synchronous memories.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  shash_pkg::cmd_t    cmd,
	output logic               digest_valid,
	input  logic               digest_stall,
	output shash_pkg::digest_t digest
);
	import shash_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_LOADH     = 3'd1;
	localparam logic [2:0] S_ROUND     = 3'd2;
	localparam logic [2:0] S_ADDH      = 3'd3;
	localparam logic [2:0] S_EMIT_RD   = 3'd4;
	localparam logic [2:0] S_EMIT_LD   = 3'd5;
	localparam logic [2:0] S_EMIT_WAIT = 3'd6;

	// kind of block being compressed
	localparam logic [1:0] K_NORMAL  = 2'd0;
	localparam logic [1:0] K_PAD     = 2'd1;
	localparam logic [1:0] K_PAD_LEN = 2'd2;
	localparam logic [1:0] K_LEN     = 2'd3;

	localparam logic [3:0] LEN_HI_WORD = 4'd14;
	localparam logic [3:0] LEN_LO_WORD = 4'd15;

	logic [2:0]  state_q;
	logic [3:0]  cnt_q;
	logic [5:0]  rnd_q;
	logic [1:0]  kind_q;
	logic [5:0]  pending_q;
	logic [63:0] msg_bits_q;
	logic [7:0]  hvalid_q;
	logic [2:0]  emit_idx_q;
	logic        digest_valid_q;
	digest_t     digest_q;
	logic [31:0] word_q;
	work_t       v_q;
	logic [15:0][31:0] sched_q;

	logic [31:0] block_mem [16];
	logic [31:0] blk_rd_q;
	logic [31:0] hash_mem [8];
	logic [31:0] hash_rd_q;
	logic        hrd_vld_q;
	logic [2:0]  hrd_addr_q;

	logic        cmd_fire;
	logic        digest_fire;
	logic        blk_we;
	logic [3:0]  blk_raddr;
	logic [2:0]  hash_raddr;
	logic        hash_we;
	logic [2:0]  hash_waddr;
	logic [31:0] hash_val;
	logic [31:0] pad_word;
	logic [31:0] blk_word;
	logic [31:0] sched_new;
	logic [31:0] w_cur;
	logic [3:0]  word_idx;
	logic [3:0]  pidx;
	work_t       v_next;

	// handshakes
	assign cmd_fire    = cmd_valid && !cmd_stall;
	assign digest_fire = digest_valid_q && !digest_stall;
	assign cmd_stall   = (state_q != S_IDLE);
	assign digest_valid = digest_valid_q;
	assign digest       = digest_q;

	// block memory port control
	assign blk_we    = cmd_fire && (cmd.op == OP_ABSORB) && (pending_q[1:0] == 2'd3);
	assign blk_raddr = (state_q == S_ROUND) ? (rnd_q[3:0] + 4'd1) : 4'd0;

	// hash memory port control
	assign hash_raddr = (state_q == S_EMIT_RD) ? emit_idx_q : cnt_q[2:0];
	assign hash_we    = (state_q == S_ADDH) && (cnt_q != 4'd0);
	assign hash_waddr = cnt_q[2:0] - 3'd1;
	assign hash_val   = hrd_vld_q ? hash_rd_q : init_hash(hrd_addr_q);

	// block memory
	always_ff @(posedge clk) begin
		if (blk_we) begin
			block_mem[pending_q[5:2]] <= {word_q[23:0], cmd.byte_value};
		end
		blk_rd_q <= block_mem[blk_raddr];
	end

	// hash memory
	always_ff @(posedge clk) begin
		if (hash_we) begin
			hash_mem[hash_waddr] <= hash_val + v_q[0];
		end
		hash_rd_q  <= hash_mem[hash_raddr];
		hrd_vld_q  <= hvalid_q[hash_raddr];
		hrd_addr_q <= hash_raddr;
	end

	// padded message words
	assign word_idx = rnd_q[3:0];
	assign pidx     = pending_q[5:2];

	always_comb begin
		case (pending_q[1:0])
			2'd0:    pad_word = {PAD_MARK, 24'h0};
			2'd1:    pad_word = {word_q[7:0], PAD_MARK, 16'h0};
			2'd2:    pad_word = {word_q[15:0], PAD_MARK, 8'h0};
			2'd3:    pad_word = {word_q[23:0], PAD_MARK};
			default: pad_word = {PAD_MARK, 24'h0};
		endcase
	end

	always_comb begin
		blk_word = blk_rd_q;
		case (kind_q)
			K_NORMAL: blk_word = blk_rd_q;
			K_PAD, K_PAD_LEN: begin
				if (word_idx == pidx) begin
					blk_word = pad_word;
				end else if (word_idx > pidx) begin
					if (kind_q == K_PAD_LEN && word_idx == LEN_HI_WORD) begin
						blk_word = msg_bits_q[63:32];
					end else if (kind_q == K_PAD_LEN && word_idx == LEN_LO_WORD) begin
						blk_word = msg_bits_q[31:0];
					end else begin
						blk_word = 32'h0;
					end
				end
			end
			K_LEN: begin
				if (word_idx == LEN_HI_WORD) begin
					blk_word = msg_bits_q[63:32];
				end else if (word_idx == LEN_LO_WORD) begin
					blk_word = msg_bits_q[31:0];
				end else begin
					blk_word = 32'h0;
				end
			end
			default: blk_word = blk_rd_q;
		endcase
	end

	// message schedule
	assign sched_new = small_sigma1(sched_q[14]) + sched_q[9] +
		small_sigma0(sched_q[1]) + sched_q[0];
	assign w_cur = (rnd_q[5:4] == 2'd0) ? blk_word : sched_new;

	shash_round u_round (
		.v      (v_q),
		.w      (w_cur),
		.k      (round_k(rnd_q)),
		.v_next (v_next)
	);

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= 4'd0;
			rnd_q          <= 6'd0;
			kind_q         <= K_NORMAL;
			pending_q      <= 6'd0;
			msg_bits_q     <= 64'd0;
			hvalid_q       <= 8'h0;
			emit_idx_q     <= 3'd0;
			digest_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						case (cmd.op)
							OP_ABSORB: begin
								pending_q <= pending_q + 6'd1;
								if (pending_q == 6'd63) begin
									msg_bits_q <= msg_bits_q + BLOCK_BITS;
									kind_q     <= K_NORMAL;
									cnt_q      <= 4'd0;
									state_q    <= S_LOADH;
								end
							end
							OP_FINAL: begin
								msg_bits_q <= msg_bits_q + {55'd0, pending_q, 3'd0};
								kind_q     <= (pending_q >= LEN_POS) ? K_PAD : K_PAD_LEN;
								cnt_q      <= 4'd0;
								state_q    <= S_LOADH;
							end
							OP_INIT: begin
								hvalid_q   <= 8'h0;
								pending_q  <= 6'd0;
								msg_bits_q <= 64'd0;
							end
							default: ;
						endcase
					end
				end
				S_LOADH: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd8) begin
						rnd_q   <= 6'd0;
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						cnt_q   <= 4'd0;
						state_q <= S_ADDH;
					end
				end
				S_ADDH: begin
					cnt_q <= cnt_q + 4'd1;
					if (hash_we) begin
						hvalid_q[hash_waddr] <= 1'b1;
					end
					if (cnt_q == 4'd8) begin
						case (kind_q)
							K_NORMAL: state_q <= S_IDLE;
							K_PAD: begin
								kind_q  <= K_LEN;
								cnt_q   <= 4'd0;
								state_q <= S_LOADH;
							end
							default: begin
								emit_idx_q <= 3'd0;
								state_q    <= S_EMIT_RD;
							end
						endcase
					end
				end
				S_EMIT_RD: state_q <= S_EMIT_LD;
				S_EMIT_LD: begin
					digest_valid_q <= 1'b1;
					state_q        <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (digest_fire) begin
						digest_valid_q <= 1'b0;
						if (emit_idx_q == 3'd7) begin
							pending_q  <= 6'd0;
							msg_bits_q <= 64'd0;
							state_q    <= S_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + 3'd1;
							state_q    <= S_EMIT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd_fire && cmd.op == OP_ABSORB) begin
			word_q <= {word_q[23:0], cmd.byte_value};
		end
		if ((state_q == S_LOADH || state_q == S_ADDH) && cnt_q != 4'd0) begin
			v_q <= {hash_val, v_q[7:1]};
		end else if (state_q == S_ROUND) begin
			v_q     <= v_next;
			sched_q <= {w_cur, sched_q[15:1]};
		end
		if (state_q == S_EMIT_LD) begin
			digest_q.digest_word <= hash_val;
			digest_q.last        <= (emit_idx_q == 3'd7);
		end
	end

	// checks
	a_digest_only_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid_q |-> (state_q == S_EMIT_WAIT))
		else $error("digest valid outside emit wait");

	a_final_starts_compress: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && cmd.op == OP_FINAL) |=> (state_q == S_LOADH))
		else $error("finalize did not start a compression");

	a_last_clears_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_fire && digest_q.last) |=> (pending_q == 6'd0 && msg_bits_q == 64'd0
			&& state_q == S_IDLE))
		else $error("counters not cleared after last digest word");

	a_hash_write_in_addh: assert property (@(posedge clk) disable iff (!arst_n)
		hash_we |-> (kind_q == K_NORMAL || kind_q == K_PAD || kind_q == K_PAD_LEN
			|| kind_q == K_LEN) && !cmd_fire)
		else $error("hash write while accepting an item");

endmodule
